// ===== rtl/core/sfq_pkg.sv =====
// Shared constants, codes and word types of the searchable FIFO queue.
`default_nettype none
package sfq_pkg;

    localparam int DEPTH      = 16;
    localparam int ITEM_BITS  = 32;
    localparam int SLOT_BITS  = $clog2(DEPTH);
    localparam int COUNT_BITS = $clog2(DEPTH + 1);
    localparam int OUT_COUNT_BITS = 5;

    localparam logic [1:0] OP_ENQ    = 2'd0;
    localparam logic [1:0] OP_DEQ    = 2'd1;
    localparam logic [1:0] OP_REMOVE = 2'd2;
    localparam logic [1:0] OP_SEARCH = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_EMPTY   = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_NOMATCH = 2'd3;

    typedef struct packed {
        logic [1:0]           op;
        logic [ITEM_BITS-1:0] item;
    } in_word_t;

    typedef struct packed {
        logic [ITEM_BITS-1:0]      item_out;
        logic [1:0]                status;
        logic [ITEM_BITS-1:0]      head_item;
        logic                      is_empty;
        logic [OUT_COUNT_BITS-1:0] entry_count;
    } out_word_t;

endpackage
`default_nettype wire

// ===== rtl/core/searchable_fifo_queue.sv =====
// Searchable FIFO queue: linked list over an item memory and a link memory.
//
// Channels: in (op and item word), out (one result word per input word) and
// cfg (writes key_mask, the bits compared by remove and search). All use
// valid/ready; cfg_ready is always high. The user writes cfg only while
// idle; the block itself does not enforce it. One input word is in flight
// at a time; in_ready is high only when idle. An enqueue passes S_ENQ;
// dequeue, remove and search walk the list from the head in S_WALK, and a
// hit of dequeue or remove then frees its slot in S_REL; full or empty
// rejects go straight to S_FIN. Every word ends in S_FIN and S_OUT.
// The next word is accepted the cycle after a result loads.
// The list walk visits one entry per cycle: the registered read of the link
// memory feeds the next read address, which bounds the rate.
// Reset empties the queue at once; link memory entries carry valid bits
// that reset clears, so no clearing pass is needed, and key_mask returns to
// all ones. A result waits in the output register while out_ready is low;
// the next word is accepted meanwhile and finishes up to the output stage.
`default_nettype none
module searchable_fifo_queue (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire sfq_pkg::in_word_t in_data,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output sfq_pkg::out_word_t     out_data,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [sfq_pkg::ITEM_BITS-1:0] cfg_data
);
    import sfq_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_ENQ  = 3'd1;
    localparam logic [2:0] S_WALK = 3'd2;
    localparam logic [2:0] S_REL  = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    logic [ITEM_BITS-1:0] item_mem [DEPTH];
    logic [SLOT_BITS-1:0] link_mem [DEPTH];
    logic [DEPTH-1:0]     link_valid_reg;

    logic [ITEM_BITS-1:0] item_rd_reg;
    logic [SLOT_BITS-1:0] link_rd_reg;
    logic                 link_rd_val_reg;
    logic [SLOT_BITS-1:0] link_rd_dflt_reg;

    logic [2:0]            state_reg, state_next;
    logic [SLOT_BITS-1:0]  head_reg, head_next;
    logic [SLOT_BITS-1:0]  tail_reg, tail_next;
    logic [SLOT_BITS-1:0]  free_reg, free_next;
    logic [COUNT_BITS-1:0] count_reg, count_next;
    logic [COUNT_BITS-1:0] walk_n_reg, walk_n_next;
    logic [SLOT_BITS-1:0]  cur_reg, cur_next;
    logic [SLOT_BITS-1:0]  prev_reg, prev_next;
    logic                  has_prev_reg, has_prev_next;
    logic [SLOT_BITS-1:0]  hit_reg, hit_next;
    logic [1:0]            op_reg, op_next;
    logic [ITEM_BITS-1:0]  word_reg, word_next;
    logic [ITEM_BITS-1:0]  found_reg, found_next;
    logic [1:0]            stat_reg, stat_next;
    logic [ITEM_BITS-1:0]  key_mask_reg;
    logic                  out_valid_reg, out_valid_next;
    out_word_t             out_data_reg, out_data_next;

    logic                  item_we;
    logic [SLOT_BITS-1:0]  item_wa, item_ra;
    logic                  link_we;
    logic [SLOT_BITS-1:0]  link_wa, link_wd, link_ra;
    logic [SLOT_BITS-1:0]  link_eff;
    logic                  is_match;
    logic                  accept;
    logic                  out_load;

    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_valid && in_ready;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Unwritten link entries read as the next slot.
    assign link_eff = link_rd_val_reg ? link_rd_reg : link_rd_dflt_reg;
    assign is_match = (op_reg == OP_DEQ)
                   || (((item_rd_reg ^ word_reg) & key_mask_reg) == '0);
    assign out_load = (state_reg == S_OUT) && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next    = state_reg;
        head_next     = head_reg;
        tail_next     = tail_reg;
        free_next     = free_reg;
        count_next    = count_reg;
        walk_n_next   = walk_n_reg;
        cur_next      = cur_reg;
        prev_next     = prev_reg;
        has_prev_next = has_prev_reg;
        hit_next      = hit_reg;
        op_next       = op_reg;
        word_next     = word_reg;
        found_next    = found_reg;
        stat_next     = stat_reg;
        out_data_next = out_data_reg;
        out_valid_next = out_valid_reg && !out_ready;
        item_we = 1'b0;
        item_wa = free_reg;
        item_ra = head_reg;
        link_we = 1'b0;
        link_wa = tail_reg;
        link_wd = free_reg;
        link_ra = head_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_data.op == OP_ENQ)
                begin
                    link_ra = free_reg;
                end
                if (accept)
                begin
                    op_next       = in_data.op;
                    word_next     = in_data.item;
                    found_next    = '0;
                    stat_next     = ST_OK;
                    cur_next      = head_reg;
                    walk_n_next   = '0;
                    has_prev_next = 1'b0;
                    if (in_data.op == OP_ENQ)
                    begin
                        if (count_reg == COUNT_BITS'(DEPTH))
                        begin
                            stat_next  = ST_FULL;
                            state_next = S_FIN;
                        end
                        else
                        begin
                            state_next = S_ENQ;
                        end
                    end
                    else if (count_reg == '0)
                    begin
                        stat_next  = ST_EMPTY;
                        state_next = S_FIN;
                    end
                    else
                    begin
                        state_next = S_WALK;
                    end
                end
            end
            S_ENQ:
            begin
                item_we   = 1'b1;
                free_next = link_eff;
                tail_next = free_reg;
                count_next = count_reg + 1'b1;
                if (count_reg == '0)
                begin
                    head_next = free_reg;
                end
                else
                begin
                    link_we = 1'b1;
                end
                state_next = S_FIN;
            end
            S_WALK:
            begin
                if (is_match)
                begin
                    found_next = item_rd_reg;
                    if (op_reg == OP_SEARCH)
                    begin
                        state_next = S_FIN;
                    end
                    else
                    begin
                        hit_next = cur_reg;
                        if (!has_prev_reg)
                        begin
                            head_next = link_eff;
                        end
                        else
                        begin
                            // splice the hit out of the chain
                            link_we = 1'b1;
                            link_wa = prev_reg;
                            link_wd = link_eff;
                            if (cur_reg == tail_reg)
                            begin
                                tail_next = prev_reg;
                            end
                        end
                        state_next = S_REL;
                    end
                end
                else if (COUNT_BITS'(walk_n_reg + 1'b1) == count_reg)
                begin
                    stat_next  = ST_NOMATCH;
                    state_next = S_FIN;
                end
                else
                begin
                    // advance to the next linked entry
                    item_ra       = link_eff;
                    link_ra       = link_eff;
                    cur_next      = link_eff;
                    prev_next     = cur_reg;
                    has_prev_next = 1'b1;
                    walk_n_next   = walk_n_reg + 1'b1;
                end
            end
            S_REL:
            begin
                link_we    = 1'b1;
                link_wa    = hit_reg;
                link_wd    = free_reg;
                free_next  = hit_reg;
                count_next = count_reg - 1'b1;
                state_next = S_FIN;
            end
            S_FIN:
            begin
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_load)
                begin
                    out_valid_next            = 1'b1;
                    out_data_next.item_out    = found_reg;
                    out_data_next.status      = stat_reg;
                    out_data_next.head_item   = (count_reg == '0) ? '0 : item_rd_reg;
                    out_data_next.is_empty    = (count_reg == '0);
                    out_data_next.entry_count = OUT_COUNT_BITS'(count_reg);
                    state_next                = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (item_we)
        begin
            item_mem[item_wa] <= word_reg;
        end
        item_rd_reg <= item_mem[item_ra];
    end

    always_ff @(posedge clk)
    begin
        if (link_we)
        begin
            link_mem[link_wa] <= link_wd;
        end
        link_rd_reg      <= link_mem[link_ra];
        link_rd_val_reg  <= link_valid_reg[link_ra];
        link_rd_dflt_reg <= (link_ra == SLOT_BITS'(DEPTH - 1)) ? '0 : link_ra + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            link_valid_reg <= '0;
            state_reg      <= S_IDLE;
            head_reg       <= '0;
            tail_reg       <= '0;
            free_reg       <= '0;
            count_reg      <= '0;
            out_valid_reg  <= 1'b0;
            key_mask_reg   <= '1;
        end
        else
        begin
            if (link_we)
            begin
                link_valid_reg[link_wa] <= 1'b1;
            end
            if (cfg_valid && cfg_ready)
            begin
                key_mask_reg <= cfg_data;
            end
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            free_reg      <= free_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        walk_n_reg   <= walk_n_next;
        cur_reg      <= cur_next;
        prev_reg     <= prev_next;
        has_prev_reg <= has_prev_next;
        hit_reg      <= hit_next;
        op_reg       <= op_next;
        word_reg     <= word_next;
        found_reg    <= found_next;
        stat_reg     <= stat_next;
        out_data_reg <= out_data_next;
    end

endmodule
`default_nettype wire

// ===== rtl/core/sfq_checker.sv =====
// Port-level checks of the searchable FIFO queue, bound to the top level.
`default_nettype none
module sfq_checker (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               in_valid,
    input wire logic               in_ready,
    input wire logic               out_valid,
    input wire logic               out_ready,
    input wire sfq_pkg::out_word_t out_data
);
    import sfq_pkg::*;

    // hold a stalled result
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("stalled result changed");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.is_empty == (out_data.entry_count == '0))
        else $error("empty flag disagrees with entry count");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.is_empty |-> out_data.head_item == '0)
        else $error("head word nonzero on empty queue");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status != ST_OK |-> out_data.item_out == '0)
        else $error("rejected op returned a word");

    // one word in flight: busy right after accept
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second word accepted while busy");

endmodule

bind searchable_fifo_queue sfq_checker u_sfq_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);
`default_nettype wire
